// File: rtl/psg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, port decode constants and register field masks for the
// sound-chip port interface.
// ----------------------------------------------------------------------------
package psg_pkg;

    localparam int NumSoundRegs = 16;
    localparam int RegIdxW      = $clog2(NumSoundRegs);

    // access kind
    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } psg_cmd_t;

    // two-phase control functions (wdata bits 7..6)
    typedef enum logic [1:0] {
        FN_INACTIVE   = 2'd0,
        FN_NOP        = 2'd1,
        FN_WRITE_REG  = 2'd2,
        FN_LATCH_ADDR = 2'd3
    } psg_fn_t;

    // port decode constants
    localparam logic [15:0] PORT_SELECT = 16'hFFFD;
    localparam logic [15:0] PORT_DATA   = 16'hBFFD;
    localparam logic [7:0]  LO_BEEPER   = 8'hFE;
    localparam logic [7:0]  HI_PPI_WR   = 8'hF4;
    localparam logic [7:0]  HI_PPI_RD   = 8'hF5;
    localparam logic [7:0]  HI_CTRL_WR  = 8'hF6;
    localparam logic [7:0]  HI_CTRL_RD  = 8'hF7;
    localparam logic [7:0]  IDLE_RDATA  = 8'hFF;
    localparam int          BeeperBit   = 4;

    // first register index not writable through the control port
    localparam logic [RegIdxW-1:0] REG_FIRST_LOCKED = RegIdxW'(14);

    localparam logic [7:0] CFG_MASK_RESET = 8'hFF;

    typedef struct packed {
        psg_cmd_t    cmd;
        logic [15:0] port;
        logic [7:0]  wdata;
    } psg_in_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       beeper_level;
    } psg_out_t;

    // valid-bit mask per register for control-port writes
    function automatic logic [7:0] field_mask(input logic [RegIdxW-1:0] r);
        logic [7:0] m;
        case (r)
            RegIdxW'(1), RegIdxW'(3), RegIdxW'(5), RegIdxW'(13): m = 8'h0F;
            RegIdxW'(6), RegIdxW'(8), RegIdxW'(9), RegIdxW'(10): m = 8'h1F;
            RegIdxW'(7): m = 8'h3F;
            default:     m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/psg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_core
// Port decode and register file: applies one bus transaction per cycle while
// fire is high and produces its read data and beeper level.
// ----------------------------------------------------------------------------
module psg_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  psg_pkg::psg_in_t item,
    input  logic [7:0]       port_mask,
    output psg_pkg::psg_out_t result
);
    import psg_pkg::*;

    logic [7:0]         sound_regs_reg [NumSoundRegs];
    logic [RegIdxW-1:0] reg_select_reg, reg_select_next;
    logic               beeper_reg, beeper_next;
    logic [7:0]         ppi_data_reg, ppi_data_next;
    psg_fn_t            pending_reg, pending_next;

    logic               reg_wr_en;
    logic [7:0]         reg_wr_data;
    logic [7:0]         hi;
    logic [7:0]         rdata;
    psg_fn_t            fn;
    logic               is_lo_beeper;

    assign hi           = item.port[15:8] & port_mask;
    assign fn           = psg_fn_t'(item.wdata[7:6]);
    assign is_lo_beeper = (item.port[7:0] == LO_BEEPER);

    always_comb begin
        reg_select_next = reg_select_reg;
        beeper_next     = beeper_reg;
        ppi_data_next   = ppi_data_reg;
        pending_next    = pending_reg;
        reg_wr_en       = 1'b0;
        reg_wr_data     = item.wdata;
        rdata           = IDLE_RDATA;

        if (item.cmd == CMD_READ) begin
            if (item.port == PORT_DATA) begin
                rdata = sound_regs_reg[reg_select_reg];
            end else if (is_lo_beeper) begin
                rdata = {7'd0, beeper_reg};
            end else if (hi == (HI_PPI_RD & port_mask) || hi == (HI_CTRL_RD & port_mask)) begin
                rdata = sound_regs_reg[reg_select_reg];
            end
        end else begin
            if (item.port == PORT_SELECT) begin
                reg_select_next = item.wdata[RegIdxW-1:0];
            end else if (item.port == PORT_DATA) begin
                reg_wr_en = 1'b1;
            end else if (is_lo_beeper) begin
                beeper_next = item.wdata[BeeperBit];
            end else if (hi == (HI_PPI_WR & port_mask)) begin
                ppi_data_next = item.wdata;
            end else if (hi == (HI_CTRL_WR & port_mask)) begin
                if (pending_reg == FN_INACTIVE) begin
                    pending_next = fn;
                end else if (fn == FN_INACTIVE) begin
                    case (pending_reg)
                        FN_LATCH_ADDR: begin
                            reg_select_next = ppi_data_reg[RegIdxW-1:0];
                        end
                        FN_WRITE_REG: begin
                            reg_wr_en   = (reg_select_reg < REG_FIRST_LOCKED);
                            reg_wr_data = ppi_data_reg & field_mask(reg_select_reg);
                        end
                        default: begin
                        end
                    endcase
                    pending_next = FN_INACTIVE;
                end
            end
        end

        result.rdata        = rdata;
        result.beeper_level = beeper_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumSoundRegs; i++) begin
                sound_regs_reg[i] <= 8'd0;
            end
            reg_select_reg <= '0;
            beeper_reg     <= 1'b0;
            ppi_data_reg   <= 8'd0;
            pending_reg    <= FN_INACTIVE;
        end else if (fire) begin
            if (reg_wr_en) begin
                sound_regs_reg[reg_select_reg] <= reg_wr_data;
            end
            reg_select_reg <= reg_select_next;
            beeper_reg     <= beeper_next;
            ppi_data_reg   <= ppi_data_next;
            pending_reg    <= pending_next;
        end
    end

endmodule

// File: rtl/psg_port_interface.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_port_interface
// Sound-chip bus interface: sixteen-entry register file reached through a
// select/data port pair or through a ppi latch and two-phase control port,
// plus a one-bit beeper latch.
// ----------------------------------------------------------------------------
// path: a transaction accepted on s_ is held in the input register, then moves
//   into the result register and is offered on m_ once that stage is free
// throughput: one transaction per cycle unless m_ready stalls both stages;
//   input register -> combinational decode and update -> result register
// reset: synchronous active-low aresetn clears the register file, select,
//   beeper, ppi latch, armed function and both valid flags; port mask -> 0xFF
// ----------------------------------------------------------------------------
module psg_port_interface (
    input  logic              aclk,
    input  logic              aresetn,
    // bus access in
    input  logic              s_valid,
    output logic              s_ready,
    input  psg_pkg::psg_in_t  s_data,
    // result out
    output logic              m_valid,
    input  logic              m_ready,
    output psg_pkg::psg_out_t m_data,
    // port mask register write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);
    import psg_pkg::*;

    psg_in_t    in_data_reg;
    logic       in_valid_reg, in_valid_next;
    psg_out_t   out_data_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] port_mask_reg;
    psg_out_t   core_result;
    logic       advance;

    // always ready; the user must change the mask only while idle, unenforced
    assign cfg_ready = 1'b1;

    // move the held transaction into the result stage when that stage is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || !out_valid_reg || m_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            port_mask_reg <= CFG_MASK_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                port_mask_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    // decode and state update happen as the transaction leaves the input stage
    psg_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .item      (in_data_reg),
        .port_mask (port_mask_reg),
        .result    (core_result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: rtl/psg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_checker
// Port-level checks on the handshake timing of the port interface.
// ----------------------------------------------------------------------------
module psg_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input psg_pkg::psg_out_t m_data
);

    // no result comes out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed or dropped");

    // input only stalls when the result side is full and stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

    // an accepted transaction reaches the output once m_ready lets it leave the input stage
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        ((s_valid && s_ready) ##1 m_ready) |=> m_valid)
        else $error("accepted transaction did not reach output");

endmodule

bind psg_port_interface psg_checker u_psg_checker (.*);

// File: test/psg_port_interface_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_port_interface_tb
// Self-checking bench for the sound-chip port interface. A queue-fed driver
// offers bus accesses on s_, a clocked monitor predicts each accepted access
// against its own copy of the register file, latches and armed function, and
// checks every m_ transaction in order. The port mask is rewritten between
// phases, with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module psg_port_interface_tb;

    import psg_pkg::*;

    localparam int StallLimit   = 3000;   // cycles with no transaction at all
    localparam int LongHoldLen  = 160;    // receiver hold-off, long enough to fill the block
    localparam int PhaseItems   = 180;    // random accesses per mask setting
    localparam int DrainCycles  = 4;      // extra wait after the queues drain, as margin

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // dut ports, the bench-driven ones known from time zero
    logic       s_valid   = 1'b0;
    logic       s_ready;
    psg_in_t    s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    psg_out_t   m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    // bench state
    psg_in_t  pending_accesses[$];   // accesses waiting for the driver
    psg_out_t expected_results[$];   // predicted m_ transactions, oldest first
    int       fail_count     = 0;
    bit       idle_enable    = 1'b1;
    int       hold_requests  = 0;    // bumped by the sequencer, served by the sink
    int       hold_served    = 0;
    int       src_gap        = 0;
    int       sink_gap       = 0;
    int       hold_left      = 0;
    int       stall_cycles   = 0;

    // predictor copy of the block state
    logic [7:0] regs_mdl [NumSoundRegs];
    logic [3:0] sel_mdl;
    logic       beep_mdl;
    logic [7:0] ppi_mdl;
    psg_fn_t    armed_mdl;
    logic [7:0] port_mask_mdl = CFG_MASK_RESET;

    psg_port_interface dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial forever #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // bits kept when the control port writes a register
    function automatic logic [7:0] ctrl_write_bits(input logic [3:0] r);
        logic [7:0] m;
        case (r)
            4'd1, 4'd3, 4'd5, 4'd13: m = 8'h0F;
            4'd6, 4'd8, 4'd9, 4'd10: m = 8'h1F;
            4'd7:                    m = 8'h3F;
            default:                 m = 8'hFF;
        endcase
        return m;
    endfunction

    // second phase of the control port: arm, or run the armed function
    task automatic step_control(input psg_fn_t fn);
        if (armed_mdl == FN_INACTIVE) begin
            armed_mdl = fn;
        end else if (fn == FN_INACTIVE) begin
            case (armed_mdl)
                FN_LATCH_ADDR: sel_mdl = ppi_mdl[3:0];
                FN_WRITE_REG: begin
                    // registers from 14 up are out of reach this way
                    if (sel_mdl < REG_FIRST_LOCKED)
                        regs_mdl[sel_mdl] = ppi_mdl & ctrl_write_bits(sel_mdl);
                end
                default: ;
            endcase
            armed_mdl = FN_INACTIVE;
        end
        // armed and another active write: ignored, function stays armed
    endtask

    // one bus access: update the copy of the state, return the result
    task automatic predict_access(input psg_in_t a, output psg_out_t r);
        logic [7:0] hi;
        logic [7:0] rd;
        hi = a.port[15:8] & port_mask_mdl;
        rd = IDLE_RDATA;
        if (a.cmd == CMD_READ) begin
            if (a.port == PORT_DATA)
                rd = regs_mdl[sel_mdl];
            else if (a.port[7:0] == LO_BEEPER)
                rd = {7'b0, beep_mdl};
            else if (hi == (HI_PPI_RD & port_mask_mdl) || hi == (HI_CTRL_RD & port_mask_mdl))
                rd = regs_mdl[sel_mdl];
        end else begin
            if (a.port == PORT_SELECT)
                sel_mdl = a.wdata[3:0];
            else if (a.port == PORT_DATA)
                regs_mdl[sel_mdl] = a.wdata;
            else if (a.port[7:0] == LO_BEEPER)
                beep_mdl = a.wdata[BeeperBit];
            else if (hi == (HI_PPI_WR & port_mask_mdl))   // wins over control on a zero mask
                ppi_mdl = a.wdata;
            else if (hi == (HI_CTRL_WR & port_mask_mdl))
                step_control(psg_fn_t'(a.wdata[7:6]));
        end
        r.rdata        = rd;
        r.beeper_level = beep_mdl;
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued accesses, random idle bursts between them
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic    nv;
        psg_in_t item;
        item = s_data;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else if (!s_valid || s_ready) begin
            // slot is free after this edge (empty, or transaction just taken)
            nv = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
            end else if (pending_accesses.size() > 0) begin
                if (idle_enable && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(1, 11) - 1;
                end else begin
                    item = pending_accesses.pop_front();
                    nv   = 1'b1;
                end
            end
            s_valid <= nv;
            s_data  <= item;
        end
        // valid high and not taken: hold valid and payload
    end

    // ------------------------------------------------------------------
    // sink: drives m_ready with idle bursts and the long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic nr;
        nr = 1'b1;
        if (!aresetn) begin
            nr        = 1'b0;
            sink_gap  = 0;
            hold_left = 0;
        end else begin
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LongHoldLen;
            end
            if (hold_left > 0) begin
                hold_left--;
                nr = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                nr = 1'b0;
            end else if (idle_enable && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 11) - 1;
                nr       = 1'b0;
            end
        end
        m_ready <= nr;
    end

    // ------------------------------------------------------------------
    // monitor: check m_ transactions, predict s_ transactions
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        psg_out_t got;
        psg_out_t want;
        psg_out_t pred;
        if (!aresetn) begin
            foreach (regs_mdl[i]) regs_mdl[i] = 8'h00;
            sel_mdl       = '0;
            beep_mdl      = 1'b0;
            ppi_mdl       = 8'h00;
            armed_mdl     = FN_INACTIVE;
            port_mask_mdl = CFG_MASK_RESET;
            expected_results.delete();
        end else begin
            // results come out in access order, so check before predicting
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual rdata=%h beeper=%b",
                             $realtime, got.rdata, got.beeper_level);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.rdata !== want.rdata) begin
                        $display("%0t: rdata mismatch, expected %h, actual %h",
                                 $realtime, want.rdata, got.rdata);
                        fail_count++;
                    end
                    if (got.beeper_level !== want.beeper_level) begin
                        $display("%0t: beeper_level mismatch, expected %b, actual %b",
                                 $realtime, want.beeper_level, got.beeper_level);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_access(s_data, pred);
                expected_results.push_back(pred);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction ends the run
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= StallLimit) begin
                $display("%0t: no transaction for %0d cycles", $realtime, StallLimit);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_access(input psg_cmd_t c, input logic [15:0] p, input logic [7:0] w);
        psg_in_t it;
        it.cmd   = c;
        it.port  = p;
        it.wdata = w;
        pending_accesses.push_back(it);
    endtask

    // a high byte that matches the given constant under the current mask
    function automatic logic [7:0] aim_hi(input logic [7:0] hb);
        return (hb & port_mask_mdl) | (8'($urandom) & ~port_mask_mdl);
    endfunction

    // low byte that keeps clear of the beeper and select/data ports
    function automatic logic [7:0] plain_lo();
        return 8'($urandom_range(0, 8'hFC));
    endfunction

    task automatic ppi_write(input logic [7:0] v);
        push_access(CMD_WRITE, {aim_hi(HI_PPI_WR), plain_lo()}, v);
    endtask

    task automatic ctrl_write(input psg_fn_t fn);
        push_access(CMD_WRITE, {aim_hi(HI_CTRL_WR), plain_lo()}, {fn, 6'($urandom)});
    endtask

    task automatic ctrl_readback();
        logic [7:0] hb;
        hb = $urandom_range(0, 1) ? HI_PPI_RD : HI_CTRL_RD;
        push_access(CMD_READ, {aim_hi(hb), plain_lo()}, 8'($urandom));
    endtask

    // sender pause: nothing left to offer and every result back
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_accesses.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (DrainCycles) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_port_mask(input logic [7:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_data  <= 8'($urandom);
        port_mask_mdl = v;
        @(negedge aclk);
    endtask

    task automatic load_directed();
        // select/data pair, highest register and extreme bytes
        push_access(CMD_READ,  PORT_DATA, 8'h5A);                 // reset value of reg 0
        push_access(CMD_WRITE, PORT_SELECT, 8'hFF);               // upper nibble dropped, reg 15
        push_access(CMD_WRITE, PORT_DATA, 8'hFF);
        push_access(CMD_READ,  PORT_DATA, 8'h00);
        // beeper set, read back, cleared with a beeper port that also looks like the ppi
        push_access(CMD_WRITE, {8'h00, LO_BEEPER}, 8'h10);
        push_access(CMD_READ,  {8'hFF, LO_BEEPER}, 8'h00);
        push_access(CMD_WRITE, {HI_PPI_WR, LO_BEEPER}, 8'hEF);
        // unmatched read and write
        push_access(CMD_READ,  16'h0000, 8'h00);
        push_access(CMD_WRITE, 16'hFFFF, 8'hFF);
        // latch address 7, with an ignored active write while armed
        push_access(CMD_WRITE, {HI_PPI_WR, 8'h00}, 8'h07);
        push_access(CMD_WRITE, {HI_CTRL_WR, 8'h00}, 8'hC0);
        push_access(CMD_WRITE, {HI_CTRL_WR, 8'h01}, 8'h40);
        push_access(CMD_WRITE, {HI_CTRL_WR, 8'h02}, 8'h00);
        // masked register write of 0xFF into reg 7
        push_access(CMD_WRITE, {HI_PPI_WR, 8'hFF}, 8'hFF);
        push_access(CMD_WRITE, {HI_CTRL_WR, 8'hFF}, 8'h80);
        push_access(CMD_WRITE, {HI_CTRL_WR, 8'h10}, 8'h3F);
        push_access(CMD_READ,  {HI_PPI_RD, 8'h00}, 8'h00);
        // locked register 14: latched, then the write is dropped
        push_access(CMD_WRITE, {HI_PPI_WR, 8'h20}, 8'h0E);
        push_access(CMD_WRITE, {HI_CTRL_WR, 8'h20}, 8'hC0);
        push_access(CMD_WRITE, {HI_CTRL_WR, 8'h21}, 8'h00);
        push_access(CMD_WRITE, {HI_PPI_WR, 8'h22}, 8'hAA);
        push_access(CMD_WRITE, {HI_CTRL_WR, 8'h22}, 8'h80);
        push_access(CMD_WRITE, {HI_CTRL_WR, 8'h23}, 8'h00);
        push_access(CMD_READ,  {HI_CTRL_RD, 8'hFD}, 8'h00);
        // no-op function armed then run
        push_access(CMD_WRITE, {HI_CTRL_WR, 8'h30}, 8'h40);
        push_access(CMD_WRITE, {HI_CTRL_WR, 8'h31}, 8'h00);
    endtask

    // mostly well-formed sequences with random content, the rest noise
    task automatic load_random(input int n);
        int      added;
        int      pick;
        int      k;
        logic [7:0] hb;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(0, 11);
            case (pick)
                0, 1: begin
                    // raw noise over the whole access space
                    push_access(psg_cmd_t'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
                    added += 1;
                end
                2, 3: begin
                    // single access aimed at one of the masked ports
                    case ($urandom_range(0, 3))
                        0: hb = HI_PPI_WR;
                        1: hb = HI_PPI_RD;
                        2: hb = HI_CTRL_WR;
                        default: hb = HI_CTRL_RD;
                    endcase
                    push_access(psg_cmd_t'($urandom_range(0, 1)),
                                {aim_hi(hb), 8'($urandom)}, 8'($urandom));
                    added += 1;
                end
                4, 5, 6: begin
                    // latch an address, write it through the control port, read back
                    ppi_write(8'($urandom));
                    ctrl_write(FN_LATCH_ADDR);
                    ctrl_write(FN_INACTIVE);
                    ppi_write(8'($urandom));
                    ctrl_write(FN_WRITE_REG);
                    ctrl_write(FN_INACTIVE);
                    ctrl_readback();
                    added += 7;
                end
                7, 8: begin
                    // select/data pair with readback on both schemes
                    push_access(CMD_WRITE, PORT_SELECT, 8'($urandom));
                    push_access(CMD_WRITE, PORT_DATA, 8'($urandom));
                    push_access(CMD_READ,  PORT_DATA, 8'($urandom));
                    ctrl_readback();
                    added += 4;
                end
                9: begin
                    // broken control sequence: random functions, re-arms, stray ppi writes
                    k = $urandom_range(2, 5);
                    repeat (k) begin
                        if ($urandom_range(0, 3) == 0)
                            ppi_write(8'($urandom));
                        else
                            ctrl_write(psg_fn_t'($urandom_range(0, 3)));
                    end
                    ctrl_readback();
                    added += k + 1;
                end
                default: begin
                    // beeper write and read on any high byte
                    push_access(CMD_WRITE, {8'($urandom), LO_BEEPER}, 8'($urandom));
                    push_access(CMD_READ,  {8'($urandom), LO_BEEPER}, 8'($urandom));
                    added += 2;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // sequencer: reset, directed part, then one random phase per mask
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] masks [8];
        masks[0] = 8'h00;                // every high byte matches
        masks[1] = 8'hFF;
        masks[2] = 8'($urandom);
        masks[3] = 8'h0F;
        masks[4] = 8'($urandom);
        masks[5] = 8'hF0;
        masks[6] = 8'($urandom);
        masks[7] = 8'hFF;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed accesses under the reset mask
        load_directed();
        wait_drained();

        foreach (masks[i]) begin
            write_port_mask(masks[i]);
            if (i == 1)
                hold_requests++;         // receiver stalls while the sender keeps offering
            if (i == 7)
                idle_enable = 1'b0;      // last phase runs at full rate
            load_random(PhaseItems);
            wait_drained();
        end

        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived, expected rdata=%h, actual none",
                     $realtime, expected_results.size(), expected_results[0].rdata);
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
